// ===== rtl/core/tdfp_pkg.sv =====
// shared types, character codes and helpers for the tagged decimal frame parser
package tdfp_pkg;

   localparam int unsigned TAG_WIDTH   = 8;
   localparam int unsigned BYTE_WIDTH  = 8;
   localparam int unsigned DIGIT_WIDTH = 4;
   localparam int unsigned NUM_DIGITS  = 4;
   localparam int unsigned COUNT_WIDTH = 14;
   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   localparam logic [TAG_WIDTH-1:0] FRAME_TAG_RESET = 8'd108;

   // register index taken from the word address
   localparam logic REG_FRAME_TAG = 1'b0;

   // item kinds
   localparam logic OP_BYTE    = 1'b0;
   localparam logic OP_TIMEOUT = 1'b1;

   localparam logic [BYTE_WIDTH-1:0] CHAR_DOT  = 8'h2E;
   localparam logic [BYTE_WIDTH-1:0] CHAR_ZERO = 8'h30;
   localparam logic [BYTE_WIDTH-1:0] CHAR_NINE = 8'h39;
   localparam logic [BYTE_WIDTH-1:0] CHAR_P    = 8'h50;
   localparam logic [BYTE_WIDTH-1:0] CHAR_U    = 8'h55;
   localparam logic [BYTE_WIDTH-1:0] CHAR_S    = 8'h53;
   localparam logic [BYTE_WIDTH-1:0] CHAR_E    = 8'h45;

   localparam logic [COUNT_WIDTH-1:0] WEIGHT_THOUSANDS = 14'd1000;
   localparam logic [COUNT_WIDTH-1:0] WEIGHT_HUNDREDS  = 14'd100;
   localparam logic [COUNT_WIDTH-1:0] WEIGHT_TENS      = 14'd10;

   typedef enum logic [2:0] {
      PHASE_TAG    = 3'd0,
      PHASE_FIELD1 = 3'd1,
      PHASE_FIELD2 = 3'd2,
      PHASE_FIELD3 = 3'd3,
      PHASE_FIELD4 = 3'd4,
      PHASE_DOT    = 3'd5
   } phase_type;

   typedef struct packed {
      logic                   valid;
      logic [COUNT_WIDTH-1:0] count_value;
      logic                   paused;
   } result_type;

   // letter of the pause word expected at a field position
   function automatic logic [BYTE_WIDTH-1:0] pause_letter(input logic [1:0] pos);
      logic [BYTE_WIDTH-1:0] letter;
      unique case (pos)
         2'd0:    letter = CHAR_P;
         2'd1:    letter = CHAR_U;
         2'd2:    letter = CHAR_S;
         default: letter = CHAR_E;
      endcase
      return letter;
   endfunction

endpackage

// ===== rtl/core/tdfp_csr.sv =====
// configuration register file with the bus port
module tdfp_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tdfp_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [tdfp_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [tdfp_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready,
   output logic [tdfp_pkg::TAG_WIDTH-1:0]      frame_tag
);
   import tdfp_pkg::*;

   logic [TAG_WIDTH-1:0] frame_tag_ff;
   logic [TAG_WIDTH-1:0] frame_tag_in;
   logic                 reg_index;
   logic                 write_hit;

   assign reg_index  = csr_paddr[CSR_ADDR_WIDTH-1];
   assign csr_pready = 1'b1;
   assign write_hit  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (reg_index == REG_FRAME_TAG);

   always_comb begin
      frame_tag_in = frame_tag_ff;
      if (write_hit) begin
         frame_tag_in = csr_pwdata[TAG_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_tag_ff <= FRAME_TAG_RESET;
      end else begin
         frame_tag_ff <= frame_tag_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_index == REG_FRAME_TAG) begin
         csr_prdata = {{(CSR_DATA_WIDTH-TAG_WIDTH){1'b0}}, frame_tag_ff};
      end
   end

   assign frame_tag = frame_tag_ff;

endmodule

// ===== rtl/core/tdfp_parser.sv =====
// frame state, digit store and result decode for one item per cycle while step is high
module tdfp_parser (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  logic                              op,
   input  logic [tdfp_pkg::BYTE_WIDTH-1:0]   rx_byte,
   input  logic [tdfp_pkg::TAG_WIDTH-1:0]    frame_tag,
   output tdfp_pkg::result_type              result
);
   import tdfp_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [DIGIT_WIDTH-1:0] digit_ff [NUM_DIGITS];
   logic [DIGIT_WIDTH-1:0] digit_in [NUM_DIGITS];
   logic                   pause_ff, pause_in;
   logic                   open_ff, open_in;
   logic                   pending_ff, pending_in;

   phase_type              phase_now;
   logic [1:0]             pos;
   logic                   is_digit;
   logic [BYTE_WIDTH-1:0]  digit_byte;
   logic [COUNT_WIDTH-1:0] digit_sum;

   assign is_digit   = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
   assign digit_byte = rx_byte - CHAR_ZERO;

   assign digit_sum = {{(COUNT_WIDTH-DIGIT_WIDTH){1'b0}}, digit_ff[0]} * WEIGHT_THOUSANDS
                    + {{(COUNT_WIDTH-DIGIT_WIDTH){1'b0}}, digit_ff[1]} * WEIGHT_HUNDREDS
                    + {{(COUNT_WIDTH-DIGIT_WIDTH){1'b0}}, digit_ff[2]} * WEIGHT_TENS
                    + {{(COUNT_WIDTH-DIGIT_WIDTH){1'b0}}, digit_ff[3]};

   always_comb begin
      phase_in   = phase_ff;
      digit_in   = digit_ff;
      pause_in   = pause_ff;
      open_in    = open_ff;
      pending_in = pending_ff;
      phase_now  = phase_ff;
      pos        = 2'd0;
      result     = '0;

      if (step) begin
         if (op == OP_TIMEOUT) begin
            pending_in = 1'b1;
            if (open_ff) begin
               open_in    = 1'b0;
               pending_in = 1'b0;
               phase_in   = PHASE_TAG;
            end
         end else begin
            // a timeout left over from before the tag aborts this frame first
            if (open_ff && pending_ff) begin
               open_in    = 1'b0;
               pending_in = 1'b0;
               phase_now  = PHASE_TAG;
               phase_in   = PHASE_TAG;
            end
            unique case (phase_now)
               PHASE_FIELD1, PHASE_FIELD2, PHASE_FIELD3, PHASE_FIELD4: begin
                  pos = 2'(phase_now - PHASE_FIELD1);
                  if (rx_byte == pause_letter(pos)) begin
                     pause_in = 1'b1;
                     phase_in = phase_type'(phase_now + 3'd1);
                  end else if (is_digit) begin
                     digit_in[pos] = digit_byte[DIGIT_WIDTH-1:0];
                     pause_in      = 1'b0;
                     phase_in      = phase_type'(phase_now + 3'd1);
                  end
               end
               PHASE_DOT: begin
                  if (rx_byte == CHAR_DOT) begin
                     open_in      = 1'b0;
                     pending_in   = 1'b0;
                     phase_in     = PHASE_TAG;
                     result.valid = 1'b1;
                     if (pause_ff) begin
                        result.paused = 1'b1;
                     end else begin
                        result.count_value = digit_sum;
                        for (int i = 0; i < NUM_DIGITS; i++) begin
                           digit_in[i] = '0;
                        end
                     end
                  end
               end
               default: begin
                  // waiting for the tag; stray codes land here too
                  phase_in = PHASE_TAG;
                  if (rx_byte == frame_tag) begin
                     phase_in = PHASE_FIELD1;
                     open_in  = 1'b1;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PHASE_TAG;
         pause_ff   <= 1'b0;
         open_ff    <= 1'b0;
         pending_ff <= 1'b0;
         for (int i = 0; i < NUM_DIGITS; i++) begin
            digit_ff[i] <= '0;
         end
      end else begin
         phase_ff   <= phase_in;
         pause_ff   <= pause_in;
         open_ff    <= open_in;
         pending_ff <= pending_in;
         digit_ff   <= digit_in;
      end
   end

endmodule

// ===== rtl/core/tagged_decimal_frame_parser_unit.sv =====
// top level: input register, frame parser, result register and config port
//
//  channel | direction | tdata (low bit up)                  | tuser
//  req     | in        | rx_byte[7:0]                        | op
//  rsp     | out       | count_value[13:0], 2 zero pad bits  | paused
//  csr     | in/out    | frame_tag at byte address 0         | -
//
// an item is taken into the input register, then parsed, and any result it gives is
// written to the output register; one item per cycle throughput while results are
// taken, with the single parse step between the two registers.
// reset clears the frame state, digit store, valid flags and loads the tag 'l'.
// when the output register holds a result that is not taken, the parse step holds;
// once the input register is full as well, req_tready drops.
module tagged_decimal_frame_parser_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // rx_byte
   input  logic                                req_tuser,  // op
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [15:0]                         rsp_tdata,  // count_value, zero pad
   output logic                                rsp_tuser,  // paused
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tdfp_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [tdfp_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [tdfp_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);
   import tdfp_pkg::*;

   logic                   in_valid_ff, in_valid_in;
   logic                   in_op_ff;
   logic [BYTE_WIDTH-1:0]  in_byte_ff;
   logic                   out_valid_ff, out_valid_in;
   logic [COUNT_WIDTH-1:0] out_count_ff;
   logic                   out_paused_ff;
   logic                   advance;
   logic                   step;
   logic [TAG_WIDTH-1:0]   frame_tag;
   result_type             result;

   tdfp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .frame_tag   (frame_tag)
   );

   tdfp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .op        (in_op_ff),
      .rx_byte   (in_byte_ff),
      .frame_tag (frame_tag),
      .result    (result)
   );

   // the output register can take a new result
   assign advance    = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = step && result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_op_ff   <= req_tuser;
         in_byte_ff <= req_tdata;
      end
      if (advance) begin
         out_count_ff  <= result.count_value;
         out_paused_ff <= result.paused;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_count_ff};
   assign rsp_tuser  = out_paused_ff;

endmodule
